FILE: sv/aigsh_pkg.sv
// ----------------------------------------------------------------------------
// aigsh_pkg
// Shared types, sizes and the slot hash for the and-inverter graph node store.
// ----------------------------------------------------------------------------
`default_nettype none

package aigsh_pkg;

   localparam int LIT_W       = 13;
   localparam int NUM_W       = 12;
   localparam int NODE_W      = 13;
   localparam int MAX_NODES   = 4096;
   localparam int TABLE_SIZE  = 8192;
   localparam int PROBE_LIMIT = 8;

   // every node must fit a 13-bit literal
   localparam int NODE_LIMIT  = (MAX_NODES < 4096) ? MAX_NODES : 4096;
   localparam int FAN_AW      = $clog2(NODE_LIMIT);
   localparam int FAN_W       = 2 * LIT_W;
   localparam int SLOT_AW     = $clog2(TABLE_SIZE);
   localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

   localparam logic ACT_INPUT = 1'b0;
   localparam logic ACT_AND   = 1'b1;

   typedef struct packed {
      logic             action;
      logic [LIT_W-1:0] lit_a;
      logic [LIT_W-1:0] lit_b;
   } aigsh_req_type;

   typedef struct packed {
      logic [LIT_W-1:0] result_lit;
      logic [NUM_W-1:0] input_number;
      logic             found_existing;
      logic             status;
   } aigsh_rsp_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_AW-1:0] addr;
      logic [NODE_W-1:0]  data;
   } aigsh_slot_wr_type;

   typedef struct packed {
      logic              en;
      logic [FAN_AW-1:0] addr;
      logic [FAN_W-1:0]  data;
   } aigsh_fan_wr_type;

   typedef struct packed {
      logic               trivial;
      logic [LIT_W-1:0]   triv_lit;
      logic [LIT_W-1:0]   key_a;
      logic [LIT_W-1:0]   key_b;
      logic [SLOT_AW-1:0] hash;
   } aigsh_dec_type;

   function automatic logic [SLOT_AW-1:0] slot_hash(input logic [LIT_W-1:0] a,
                                                   input logic [LIT_W-1:0] b);
      logic [31:0] aa;
      logic [31:0] bb;
      logic [31:0] h;
      aa = 32'(a);
      bb = 32'(b);
      h  = (aa << 5) ^ (aa >> 3) ^ ((bb << 1) + bb);
      return h[SLOT_AW-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/aigsh_decode.sv
// ----------------------------------------------------------------------------
// aigsh_decode
// Trivial-case simplification, operand ordering and slot hash of an and request.
// ----------------------------------------------------------------------------
`default_nettype none

module aigsh_decode (
   input  wire logic [aigsh_pkg::LIT_W-1:0] lit_a,
   input  wire logic [aigsh_pkg::LIT_W-1:0] lit_b,
   output aigsh_pkg::aigsh_dec_type         dec
);
   import aigsh_pkg::*;

   logic [LIT_W-2:0] node_a;
   logic [LIT_W-2:0] node_b;
   logic [LIT_W-1:0] big;
   logic [LIT_W-1:0] sml;

   assign node_a = lit_a[LIT_W-1:1];
   assign node_b = lit_b[LIT_W-1:1];

   // larger node goes first
   assign big = (node_a < node_b) ? lit_b : lit_a;
   assign sml = (node_a < node_b) ? lit_a : lit_b;

   always_comb begin
      dec.key_a    = big;
      dec.key_b    = sml;
      dec.hash     = slot_hash(big, sml);
      dec.trivial  = 1'b1;
      dec.triv_lit = '0;
      if (lit_a == '0 || lit_b == '0) begin
         dec.triv_lit = '0;
      end else if (lit_a == LIT_W'(1)) begin
         dec.triv_lit = lit_b;
      end else if (lit_b == LIT_W'(1)) begin
         dec.triv_lit = lit_a;
      end else if (lit_a == lit_b) begin
         dec.triv_lit = lit_a;
      end else if (node_a == node_b) begin
         // complementary operands
         dec.triv_lit = '0;
      end else begin
         dec.trivial = 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: sv/aigsh_slot_table.sv
// ----------------------------------------------------------------------------
// aigsh_slot_table
// Open-addressed slot table memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module aigsh_slot_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [aigsh_pkg::SLOT_AW-1:0] rd_addr,
   output logic [aigsh_pkg::NODE_W-1:0]       rd_data,
   input  wire aigsh_pkg::aigsh_slot_wr_type  wr,
   output logic                               busy
);
   import aigsh_pkg::*;

   logic [NODE_W-1:0]  mem [TABLE_SIZE];
   logic [SLOT_AW-1:0] clr_idx_ff;
   logic               busy_ff;
   logic [NODE_W-1:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
      end else if (busy_ff) begin
         clr_idx_ff <= clr_idx_ff + SLOT_AW'(1);
         if (clr_idx_ff == SLOT_AW'(TABLE_SIZE - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

FILE: sv/aigsh_fanin_store.sv
// ----------------------------------------------------------------------------
// aigsh_fanin_store
// Fanin pair memory, one entry per node, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aigsh_fanin_store (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [aigsh_pkg::FAN_AW-1:0] rd_addr,
   output logic [aigsh_pkg::FAN_W-1:0]       rd_data,
   input  wire aigsh_pkg::aigsh_fan_wr_type  wr
);
   import aigsh_pkg::*;

   logic [FAN_W-1:0] mem [NODE_LIMIT];
   logic [FAN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/aig_structural_hash_and.sv
// ----------------------------------------------------------------------------
// aig_structural_hash_and
// And-inverter graph node store with structural hashing of and nodes.
// ----------------------------------------------------------------------------
// usage:
//   req_word carries action, lit_a and lit_b; each accepted word gives exactly
//   one rsp_word (result_lit, input_number, found_existing, status).
//   one request is worked at a time; req_ready rises again once the result
//   has been moved to the output register.
//   from accept to rsp_valid, an input node or a trivial and passes DECIDE
//   and OUT; a new and node placed at the first probe passes DECIDE,
//   SLOT_CHK and OUT; a match at the first probe passes DECIDE, SLOT_CHK,
//   FAN_CHK and OUT; each further probe adds SLOT_CHK and FAN_CHK, for at
//   most PROBE_LIMIT (8) probes. each probe costs one slot table read and,
//   for an occupied slot, one fanin store read, both registered-read memories.
//   after reset the slot table is swept to empty, one slot per cycle, and
//   req_ready stays low until the sweep is done.
//   a stalled rsp_word holds in its register; the next request may be taken
//   and worked meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module aig_structural_hash_and (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire aigsh_pkg::aigsh_req_type req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output aigsh_pkg::aigsh_rsp_type     rsp_word
);
   import aigsh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SLOT_CHK,
      ST_FAN_CHK,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   aigsh_req_type      op_ff, op_in;
   logic [LIT_W-1:0]   key_a_ff, key_a_in;
   logic [LIT_W-1:0]   key_b_ff, key_b_in;
   logic [SLOT_AW-1:0] idx_ff, idx_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic [NODE_W-1:0]  held_ff, held_in;
   logic [NODE_W-1:0]  next_node_ff, next_node_in;
   logic [NUM_W-1:0]   input_count_ff, input_count_in;
   aigsh_rsp_type      res_ff, res_in;
   aigsh_rsp_type      rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   aigsh_dec_type      dec;
   logic               slot_rd_en;
   logic [SLOT_AW-1:0] slot_rd_addr;
   logic [NODE_W-1:0]  slot_rdata;
   aigsh_slot_wr_type  slot_wr;
   logic               clr_busy;
   logic               fan_rd_en;
   logic [FAN_AW-1:0]  fan_rd_addr;
   logic [FAN_W-1:0]   fan_rdata;
   aigsh_fan_wr_type   fan_wr;
   logic               full;
   logic [LIT_W-1:0]   new_lit;
   logic [LIT_W-1:0]   held_lit;

   aigsh_decode u_decode (
      .lit_a (op_ff.lit_a),
      .lit_b (op_ff.lit_b),
      .dec   (dec)
   );

   aigsh_slot_table u_slot_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rdata),
      .wr      (slot_wr),
      .busy    (clr_busy)
   );

   aigsh_fanin_store u_fanin_store (
      .clock   (clock),
      .rd_en   (fan_rd_en),
      .rd_addr (fan_rd_addr),
      .rd_data (fan_rdata),
      .wr      (fan_wr)
   );

   assign full     = (next_node_ff >= NODE_W'(NODE_LIMIT));
   assign new_lit  = {next_node_ff[LIT_W-2:0], 1'b0};
   assign held_lit = {held_ff[LIT_W-2:0], 1'b0};

   assign req_ready = (state_ff == ST_IDLE) && !clr_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_a_in       = key_a_ff;
      key_b_in       = key_b_ff;
      idx_in         = idx_ff;
      probe_in       = probe_ff;
      held_in        = held_ff;
      next_node_in   = next_node_ff;
      input_count_in = input_count_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      slot_rd_en     = 1'b0;
      slot_rd_addr   = dec.hash;
      slot_wr        = '0;
      fan_rd_en      = 1'b0;
      fan_rd_addr    = slot_rdata[FAN_AW-1:0];
      fan_wr         = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               op_in    = req_word;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (op_ff.action == ACT_INPUT) begin
               if (full) begin
                  res_in = '{result_lit: '0, input_number: '0,
                             found_existing: 1'b0, status: 1'b1};
               end else begin
                  fan_wr.en      = 1'b1;
                  fan_wr.addr    = next_node_ff[FAN_AW-1:0];
                  fan_wr.data    = FAN_W'(input_count_ff);
                  res_in         = '{result_lit: new_lit, input_number: input_count_ff,
                                     found_existing: 1'b0, status: 1'b0};
                  next_node_in   = next_node_ff + NODE_W'(1);
                  input_count_in = input_count_ff + NUM_W'(1);
               end
               state_in = ST_OUT;
            end else if (dec.trivial) begin
               res_in   = '{result_lit: dec.triv_lit, input_number: '0,
                            found_existing: 1'b1, status: 1'b0};
               state_in = ST_OUT;
            end else begin
               key_a_in   = dec.key_a;
               key_b_in   = dec.key_b;
               idx_in     = dec.hash;
               probe_in   = '0;
               slot_rd_en = 1'b1;
               state_in   = ST_SLOT_CHK;
            end
         end
         ST_SLOT_CHK: begin
            if (slot_rdata == '0) begin
               if (full) begin
                  res_in = '{result_lit: '0, input_number: '0,
                             found_existing: 1'b0, status: 1'b1};
               end else begin
                  slot_wr.en   = 1'b1;
                  slot_wr.addr = idx_ff;
                  slot_wr.data = next_node_ff;
                  fan_wr.en    = 1'b1;
                  fan_wr.addr  = next_node_ff[FAN_AW-1:0];
                  fan_wr.data  = {key_a_ff, key_b_ff};
                  res_in       = '{result_lit: new_lit, input_number: '0,
                                   found_existing: 1'b0, status: 1'b0};
                  next_node_in = next_node_ff + NODE_W'(1);
               end
               state_in = ST_OUT;
            end else begin
               fan_rd_en = 1'b1;
               held_in   = slot_rdata;
               state_in  = ST_FAN_CHK;
            end
         end
         ST_FAN_CHK: begin
            if (fan_rdata == {key_a_ff, key_b_ff}) begin
               res_in   = '{result_lit: held_lit, input_number: '0,
                            found_existing: 1'b1, status: 1'b0};
               state_in = ST_OUT;
            end else if (probe_ff == PROBE_W'(PROBE_LIMIT - 1)) begin
               // probe window exhausted
               res_in   = '{result_lit: '0, input_number: '0,
                            found_existing: 1'b0, status: 1'b1};
               state_in = ST_OUT;
            end else begin
               probe_in     = probe_ff + PROBE_W'(1);
               idx_in       = idx_ff + SLOT_AW'(1);
               slot_rd_en   = 1'b1;
               slot_rd_addr = idx_ff + SLOT_AW'(1);
               state_in     = ST_SLOT_CHK;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_node_ff   <= NODE_W'(1);
         input_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_node_ff   <= next_node_in;
         input_count_ff <= input_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff    <= op_in;
      key_a_ff <= key_a_in;
      key_b_ff <= key_b_in;
      idx_ff   <= idx_in;
      probe_ff <= probe_in;
      held_ff  <= held_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // no request taken while the slot table is being swept
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready)
      else $error("request accepted during slot table clear");

   // node counter never passes the node limit
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      next_node_ff <= NODE_W'(NODE_LIMIT))
      else $error("node counter beyond node limit");

   // probe index stays inside the probe window
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FAN_CHK |-> probe_ff <= PROBE_W'(PROBE_LIMIT - 1))
      else $error("probe index outside window");

   // a full status comes with a zero, not-found result
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> rsp_ff.result_lit == '0 && !rsp_ff.found_existing)
      else $error("full status with nonzero result");

   // new nodes always give a plain literal, so an inverted one was found
   a_odd_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_lit[0] |-> rsp_ff.found_existing)
      else $error("inverted literal on a freshly made node");

endmodule

`default_nettype wire

FILE: dv/tb_aig_structural_hash_and.sv
// ----------------------------------------------------------------------------
// tb_aig_structural_hash_and
// Checks the and-inverter graph node store: a shadow of the node store and
// slot table predicts every result word. Directed words hit the trivial and
// cases, random words build graphs and force hash collisions, and a last
// phase looks existing and nodes up again.
// ----------------------------------------------------------------------------
module tb_aig_structural_hash_and;
   timeunit 1ns;
   timeprecision 1ps;

   import aigsh_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef enum {TRIV_ZERO, TRIV_ONE, TRIV_SAME, TRIV_CPL} triv_kind_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   aigsh_req_type req_word = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   aigsh_rsp_type rsp_word;

   aig_structural_hash_and dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the node store
   logic [FAN_W-1:0]  fanins [NODE_LIMIT];
   bit   [NODE_W-1:0] slots [TABLE_SIZE];
   int unsigned       next_free = 1;
   logic [NUM_W-1:0]  inputs_made = '0;
   logic [LIT_W-1:0]  live_lits [$];
   logic [FAN_W-1:0]  and_pairs [$];

   aigsh_req_type backlog [$];
   aigsh_rsp_type pending_answers [$];

   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   int unsigned words_queued = 0;
   bit          req_moved = 1'b0;
   bit          rsp_moved = 1'b0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;

   function automatic aigsh_rsp_type strash_apply(aigsh_req_type w);
      aigsh_rsp_type    r;
      logic [LIT_W-1:0] a, b, t;
      logic [FAN_W-1:0] key;
      int unsigned      ua, ub, h, idx, held, k;
      r = '0;
      a = w.lit_a;
      b = w.lit_b;
      if (w.action == ACT_INPUT) begin
         if (next_free >= NODE_LIMIT) begin
            r.status = 1'b1;
            return r;
         end
         fanins[next_free] = FAN_W'(inputs_made);
         r.result_lit = LIT_W'(next_free << 1);
         r.input_number = inputs_made;
         live_lits = {live_lits, r.result_lit};
         next_free = next_free + 1;
         inputs_made = inputs_made + 1'b1;
         return r;
      end
      r.found_existing = 1'b1;
      if (a == 0 || b == 0) return r;
      if (a == 1) begin
         r.result_lit = b;
         return r;
      end
      if (b == 1 || a == b) begin
         r.result_lit = a;
         return r;
      end
      // complementary literals of one node
      if (a[LIT_W-1:1] == b[LIT_W-1:1]) return r;
      if (a[LIT_W-1:1] < b[LIT_W-1:1]) begin
         t = a;
         a = b;
         b = t;
      end
      key = {a, b};
      ua = a;
      ub = b;
      h = ((ua * 32) ^ (ua / 8) ^ (ub * 3)) % TABLE_SIZE;
      r.found_existing = 1'b0;
      for (k = 0; k < PROBE_LIMIT; k++) begin
         idx = (h + k) % TABLE_SIZE;
         held = slots[idx];
         if (held == 0) begin
            if (next_free >= NODE_LIMIT) begin
               r.status = 1'b1;
               return r;
            end
            fanins[next_free] = key;
            slots[idx] = NODE_W'(next_free);
            r.result_lit = LIT_W'(next_free << 1);
            live_lits = {live_lits, r.result_lit};
            and_pairs = {and_pairs, key};
            next_free = next_free + 1;
            return r;
         end
         if (fanins[held] == key) begin
            r.result_lit = LIT_W'(held << 1);
            r.found_existing = 1'b1;
            return r;
         end
      end
      r.status = 1'b1;
      return r;
   endfunction

   task automatic compare_field(input string what, input logic [LIT_W-1:0] want,
                                input logic [LIT_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // capture accepted words on both channels
   always @(posedge clock) begin
      aigsh_rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_answers = {pending_answers, strash_apply(req_word)};
            req_moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_moved = 1'b1;
            if (pending_answers.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_word);
            end else begin
               want = pending_answers.pop_front();
               compare_field("result_lit", want.result_lit, rsp_word.result_lit);
               compare_field("input_number", LIT_W'(want.input_number),
                             LIT_W'(rsp_word.input_number));
               compare_field("found_existing", LIT_W'(want.found_existing),
                             LIT_W'(rsp_word.found_existing));
               compare_field("status", LIT_W'(want.status), LIT_W'(rsp_word.status));
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_moved)) begin
         if (req_wait > 0) begin
            req_wait = req_wait - 1;
            req_valid <= 1'b0;
         end else if (backlog.size() > 0) begin
            req_word <= backlog.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
            req_wait = req_quiet ? 0 : $urandom_range(0, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_moved = 1'b0;
   end

   // result receiver: each word waits out its stall while it is visible
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_moved) begin
            if ($urandom_range(0, 49) == 0) rsp_quiet = !rsp_quiet;
            rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 11);
         end
         if (rsp_wait == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            if (rsp_valid) rsp_wait = rsp_wait - 1;
         end
      end
      rsp_moved = 1'b0;
   end

   task automatic push_req(input logic act, input logic [LIT_W-1:0] a,
                           input logic [LIT_W-1:0] b);
      aigsh_req_type w;
      while (backlog.size() >= 3) @(posedge clock);
      w.action = act;
      w.lit_a = a;
      w.lit_b = b;
      backlog = {backlog, w};
      words_queued++;
   endtask

   // checked at the rising edge, where driver and queue state are settled
   task automatic wait_all_answered();
      do @(posedge clock);
      while (backlog.size() != 0 || req_valid || pending_answers.size() != 0);
   endtask

   function automatic logic [LIT_W-1:0] any_live_lit();
      if (live_lits.size() == 0) return LIT_W'($urandom_range(2, 8191));
      return live_lits[$urandom_range(0, live_lits.size() - 1)] ^ LIT_W'($urandom_range(0, 1));
   endfunction

   task automatic live_and();
      push_req(ACT_AND, any_live_lit(), any_live_lit());
   endtask

   task automatic repeat_and();
      logic [FAN_W-1:0] p;
      if (and_pairs.size() == 0) begin
         live_and();
      end else begin
         p = and_pairs[$urandom_range(0, and_pairs.size() - 1)];
         if ($urandom_range(0, 1)) push_req(ACT_AND, p[FAN_W-1:LIT_W], p[LIT_W-1:0]);
         else push_req(ACT_AND, p[LIT_W-1:0], p[FAN_W-1:LIT_W]);
      end
   endtask

   task automatic trivial_and();
      logic [LIT_W-1:0] x;
      bit               flip;
      x = any_live_lit();
      flip = $urandom_range(0, 1);
      case (triv_kind_type'($urandom_range(0, 3)))
         TRIV_ZERO: if (flip) push_req(ACT_AND, 0, x); else push_req(ACT_AND, x, 0);
         TRIV_ONE:  if (flip) push_req(ACT_AND, 1, x); else push_req(ACT_AND, x, 1);
         TRIV_SAME: push_req(ACT_AND, x, x);
         default:   push_req(ACT_AND, x, x ^ 1'b1);
      endcase
   endtask

   // pairs that all hash to one slot: fills the probe window, overflows it,
   // then looks a randomly chosen one of them up again
   task automatic collision_burst();
      int unsigned      h, a, b, x, n;
      logic [FAN_W-1:0] pairs [$];
      logic [FAN_W-1:0] pr;
      h = $urandom_range(0, TABLE_SIZE - 1);
      n = $urandom_range(PROBE_LIMIT + 1, PROBE_LIMIT + 2);
      while (pairs.size() < n) begin
         a = $urandom_range(4, 8191);
         x = (h ^ (a * 32) ^ (a / 8)) & 32'h1fff;
         // 2731 is the inverse of 3 modulo the table size
         b = (x * 2731) & 32'h1fff;
         if (b >= 2 && (b >> 1) < (a >> 1)) begin
            pr = {LIT_W'(a), LIT_W'(b)};
            pairs = {pairs, pr};
            if ($urandom_range(0, 1)) push_req(ACT_AND, LIT_W'(a), LIT_W'(b));
            else push_req(ACT_AND, LIT_W'(b), LIT_W'(a));
         end
      end
      x = $urandom_range(0, pairs.size() - 1);
      push_req(ACT_AND, pairs[x][LIT_W-1:0], pairs[x][FAN_W-1:LIT_W]);
   endtask

   initial begin
      int unsigned r, start;
      bit          paused;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_req(ACT_INPUT, 0, 0);
      push_req(ACT_INPUT, 13'h1fff, 13'h1fff);
      push_req(ACT_INPUT, 13'h0aaa, 13'h1555);
      push_req(ACT_AND, 0, 4);
      push_req(ACT_AND, 6, 0);
      push_req(ACT_AND, 1, 6);
      push_req(ACT_AND, 5, 1);
      push_req(ACT_AND, 1, 1);
      push_req(ACT_AND, 0, 0);
      push_req(ACT_AND, 1, 0);
      push_req(ACT_AND, 4, 4);
      push_req(ACT_AND, 7, 7);
      push_req(ACT_AND, 4, 5);
      push_req(ACT_AND, 2, 6);
      push_req(ACT_AND, 6, 2);
      push_req(ACT_AND, 7, 3);
      push_req(ACT_AND, 9, 4);
      push_req(ACT_AND, 13'h1fff, 13'h1ffe);
      push_req(ACT_AND, 13'h1fff, 2);
      push_req(ACT_AND, 2, 13'h1fff);
      push_req(ACT_AND, 13'h1ffe, 13'h1ffd);
      push_req(ACT_AND, 13'h1fff, 1);
      wait_all_answered();

      start = words_queued;
      paused = 1'b0;
      while (words_queued - start < 1660) begin
         r = $urandom_range(0, 99);
         if (r < 15) push_req(ACT_INPUT, LIT_W'($urandom), LIT_W'($urandom));
         else if (r < 50) live_and();
         else if (r < 65) repeat_and();
         else if (r < 75) trivial_and();
         else if (r < 97) push_req(1'($urandom_range(0, 1)), LIT_W'($urandom),
                                   LIT_W'($urandom));
         else collision_burst();
         if (!paused && words_queued - start >= 830) begin
            paused = 1'b1;
            wait_all_answered();
         end
      end
      wait_all_answered();

      // existing nodes must still be found after the graph has grown
      repeat (120) begin
         r = $urandom_range(0, 99);
         if (r < 40) repeat_and();
         else if (r < 65) live_and();
         else if (r < 80) push_req(ACT_INPUT, LIT_W'($urandom), LIT_W'($urandom));
         else if (r < 90) trivial_and();
         else push_req(ACT_AND, LIT_W'($urandom), LIT_W'($urandom));
      end
      wait_all_answered();
      repeat (40) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/aigsh_pkg.sv
sv/aigsh_decode.sv
sv/aigsh_slot_table.sv
sv/aigsh_fanin_store.sv
sv/aig_structural_hash_and.sv
dv/tb_aig_structural_hash_and.sv
